### design/rlp_transaction_field_parser_assert.svh
// Assertion macros used by the checker file rlp_tfp_checker.sv.
`ifndef RLP_TRANSACTION_FIELD_PARSER_ASSERT_SVH
`define RLP_TRANSACTION_FIELD_PARSER_ASSERT_SVH

// Assertion on an explicit clock and active-low reset.
`define RLP_TFP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block's clk_i / rst_ni.
`define RLP_TFP_ASSERT(label, prop, msg) \
  `RLP_TFP_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### design/rlp_tfp_pkg.sv
`default_nettype none

package rlp_tfp_pkg;

  typedef enum logic [4:0] {
    PH_OUTER     = 5'b00001,
    PH_OUTER_LEN = 5'b00010,
    PH_ITEM      = 5'b00100,
    PH_ITEM_LEN  = 5'b01000,
    PH_BODY      = 5'b10000
  } phase_e;

  localparam logic [3:0] FIELD_NONCE     = 4'd0;
  localparam logic [3:0] FIELD_GAS_PRICE = 4'd1;
  localparam logic [3:0] FIELD_GAS_LIMIT = 4'd2;
  localparam logic [3:0] FIELD_TO        = 4'd3;
  localparam logic [3:0] FIELD_VALUE     = 4'd4;
  localparam logic [3:0] FIELD_DATA      = 4'd5;
  localparam logic [3:0] FIELD_V         = 4'd6;
  localparam logic [3:0] FIELD_DONE      = 4'd7;
  localparam logic [3:0] FIELD_NO_LIST   = 4'd15;

  localparam logic [7:0] LIST_LONG_MIN   = 8'hf8;
  localparam logic [7:0] LIST_LEN_BASE   = 8'hf7;
  localparam logic [7:0] LIST_SHORT_MIN  = 8'hc0;
  localparam logic [7:0] STR_LONG_MIN    = 8'hb8;
  localparam logic [7:0] STR_LEN_BASE    = 8'hb7;
  localparam logic [7:0] STR_SHORT_MIN   = 8'h80;
  localparam logic [7:0] V_OFFSET        = 8'd35;
  localparam logic [7:0] V_MIN           = 8'd37;

  localparam logic [15:0] NONCE_MAX_LEN     = 16'd4;
  localparam logic [15:0] GAS_PRICE_MAX_LEN = 16'd5;
  localparam logic [15:0] GAS_LIMIT_MAX_LEN = 16'd4;
  localparam logic [15:0] ADDRESS_LEN       = 16'd20;
  localparam logic [15:0] VALUE_MAX_LEN     = 16'd32;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] nonce;
    logic [23:0] gas_price_high;
    logic [15:0] gas_price_low;
    logic [31:0] gas_limit;
    logic        has_address;
    logic [15:0] address_offset;
    logic [15:0] value_offset;
    logic [5:0]  value_length;
    logic [15:0] data_offset;
    logic [15:0] data_length;
    logic [6:0]  chain_id;
  } result_t;

endpackage

`default_nettype wire

### design/rlp_tfp_if.sv
`default_nettype none

interface rlp_tfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last;

  modport source (output valid, output byte_in, output last, input ready);
  modport sink   (input valid, input byte_in, input last, output ready);
endinterface

interface rlp_tfp_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] nonce;
  logic [23:0] gas_price_high;
  logic [15:0] gas_price_low;
  logic [31:0] gas_limit;
  logic        has_address;
  logic [15:0] address_offset;
  logic [15:0] value_offset;
  logic [5:0]  value_length;
  logic [15:0] data_offset;
  logic [15:0] data_length;
  logic [6:0]  chain_id;

  modport source (
    output valid, output ok, output nonce, output gas_price_high, output gas_price_low,
    output gas_limit, output has_address, output address_offset, output value_offset,
    output value_length, output data_offset, output data_length, output chain_id,
    input ready
  );
  modport sink (
    input valid, input ok, input nonce, input gas_price_high, input gas_price_low,
    input gas_limit, input has_address, input address_offset, input value_offset,
    input value_length, input data_offset, input data_length, input chain_id,
    output ready
  );
endinterface

`default_nettype wire

### design/rlp_tfp_core.sv
`default_nettype none

module rlp_tfp_core #(
  parameter int POSITION_BITS = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   step_i,
  input  rlp_tfp_pkg::beat_t    beat_i,
  output logic                  res_valid_o,
  output rlp_tfp_pkg::result_t  res_o
);

  localparam int PW = POSITION_BITS;
  localparam int LW = ((PW > 16) ? PW : 16) + 1;

  rlp_tfp_pkg::phase_e phase_q, phase_d;
  logic [3:0]    fi_q, fi_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          err_q, err_d;
  logic [LW-1:0] list_end_q, list_end_d;
  logic [LW-1:0] item_end_q, item_end_d;
  logic [3:0]    lbl_q, lbl_d;
  logic [15:0]   len_acc_q, len_acc_d;
  logic [39:0]   num_acc_q, num_acc_d;
  logic          item_one_q, item_one_d;
  logic [31:0]   nonce_q, nonce_d;
  logic [39:0]   gas_price_q, gas_price_d;
  logic [31:0]   gas_limit_q, gas_limit_d;
  logic          has_addr_q, has_addr_d;
  logic [15:0]   addr_off_q, addr_off_d;
  logic [15:0]   val_off_q, val_off_d;
  logic [5:0]    val_len_q, val_len_d;
  logic [15:0]   data_off_q, data_off_d;
  logic [15:0]   data_len_q, data_len_d;
  logic [6:0]    chain_q, chain_d;

  logic [7:0]    b;
  logic [LW-1:0] cur_x, cur_p1;
  logic          begin_v, begin_bare;
  logic [LW-1:0] begin_start, begin_end;
  logic [15:0]   begin_len;
  logic          fin_v, fin_one;
  logic [39:0]   fin_acc;
  logic [7:0]    v_minus;
  logic          ok;

  assign b      = beat_i.byte_in;
  assign cur_x  = LW'(pos_q);
  assign cur_p1 = cur_x + LW'(1);

  always_comb begin
    phase_d     = phase_q;
    fi_d        = fi_q;
    pos_d       = pos_q;
    err_d       = err_q;
    list_end_d  = list_end_q;
    item_end_d  = item_end_q;
    lbl_d       = lbl_q;
    len_acc_d   = len_acc_q;
    num_acc_d   = num_acc_q;
    item_one_d  = item_one_q;
    nonce_d     = nonce_q;
    gas_price_d = gas_price_q;
    gas_limit_d = gas_limit_q;
    has_addr_d  = has_addr_q;
    addr_off_d  = addr_off_q;
    val_off_d   = val_off_q;
    val_len_d   = val_len_q;
    data_off_d  = data_off_q;
    data_len_d  = data_len_q;
    chain_d     = chain_q;
    begin_v     = 1'b0;
    begin_bare  = 1'b0;
    begin_start = cur_p1;
    begin_len   = 16'd0;
    begin_end   = '0;
    fin_v       = 1'b0;
    fin_one     = item_one_q;
    fin_acc     = {num_acc_q[31:0], b};
    v_minus     = 8'd0;
    ok          = 1'b0;
    res_o       = '0;

    if (step_i) begin
      if (!err_q) begin
        if (pos_q == '1) begin
          err_d = 1'b1;
        end else begin
          case (phase_q)
            rlp_tfp_pkg::PH_OUTER: begin
              if (b >= rlp_tfp_pkg::LIST_LONG_MIN) begin
                lbl_d     = 4'(b - rlp_tfp_pkg::LIST_LEN_BASE);
                len_acc_d = 16'd0;
                phase_d   = rlp_tfp_pkg::PH_OUTER_LEN;
              end else if (b >= rlp_tfp_pkg::LIST_SHORT_MIN) begin
                list_end_d = cur_p1 + LW'(b - rlp_tfp_pkg::LIST_SHORT_MIN);
                fi_d       = rlp_tfp_pkg::FIELD_NONCE;
                phase_d    = rlp_tfp_pkg::PH_ITEM;
              end else begin
                err_d = 1'b1;
              end
            end
            rlp_tfp_pkg::PH_OUTER_LEN: begin
              len_acc_d = {len_acc_q[7:0], b};
              if (lbl_q != 4'd0) lbl_d = lbl_q - 4'd1;
              if (lbl_d == 4'd0) begin
                list_end_d = cur_p1 + LW'(len_acc_d);
                fi_d       = rlp_tfp_pkg::FIELD_NONCE;
                phase_d    = rlp_tfp_pkg::PH_ITEM;
              end
            end
            default: begin
              if (cur_x >= list_end_q) begin
                err_d = 1'b1;
              end else begin
                case (phase_q)
                  rlp_tfp_pkg::PH_ITEM: begin
                    if (b >= rlp_tfp_pkg::LIST_SHORT_MIN) begin
                      err_d = 1'b1;
                    end else if (b >= rlp_tfp_pkg::STR_LONG_MIN) begin
                      lbl_d     = 4'(b - rlp_tfp_pkg::STR_LEN_BASE);
                      len_acc_d = 16'd0;
                      phase_d   = rlp_tfp_pkg::PH_ITEM_LEN;
                    end else if (b >= rlp_tfp_pkg::STR_SHORT_MIN) begin
                      begin_v   = 1'b1;
                      begin_len = 16'(b - rlp_tfp_pkg::STR_SHORT_MIN);
                    end else begin
                      begin_v     = 1'b1;
                      begin_bare  = 1'b1;
                      begin_start = cur_x;
                      begin_len   = 16'd1;
                    end
                  end
                  rlp_tfp_pkg::PH_ITEM_LEN: begin
                    len_acc_d = {len_acc_q[7:0], b};
                    if (lbl_q != 4'd0) lbl_d = lbl_q - 4'd1;
                    if (lbl_d == 4'd0) begin
                      begin_v   = 1'b1;
                      begin_len = len_acc_d;
                    end
                  end
                  rlp_tfp_pkg::PH_BODY: begin
                    num_acc_d = fin_acc;
                    if (cur_p1 >= item_end_q) fin_v = 1'b1;
                  end
                  default: begin
                    err_d = 1'b1;
                  end
                endcase
              end
            end
          endcase
        end
      end

      // Item header complete: length checks and offset capture.
      if (begin_v) begin
        begin_end  = begin_start + LW'(begin_len);
        item_end_d = begin_end;
        if (begin_end > list_end_q) begin
          err_d = 1'b1;
        end else begin
          case (fi_q)
            rlp_tfp_pkg::FIELD_NONCE: begin
              if (begin_len > rlp_tfp_pkg::NONCE_MAX_LEN) err_d = 1'b1;
            end
            rlp_tfp_pkg::FIELD_GAS_PRICE: begin
              if (begin_len > rlp_tfp_pkg::GAS_PRICE_MAX_LEN) err_d = 1'b1;
            end
            rlp_tfp_pkg::FIELD_GAS_LIMIT: begin
              if (begin_len > rlp_tfp_pkg::GAS_LIMIT_MAX_LEN) err_d = 1'b1;
            end
            rlp_tfp_pkg::FIELD_TO: begin
              if (begin_len != 16'd0 && begin_len != rlp_tfp_pkg::ADDRESS_LEN) err_d = 1'b1;
              has_addr_d = (begin_len == rlp_tfp_pkg::ADDRESS_LEN);
              addr_off_d = begin_start[15:0];
            end
            rlp_tfp_pkg::FIELD_VALUE: begin
              if (begin_len > rlp_tfp_pkg::VALUE_MAX_LEN) err_d = 1'b1;
              val_off_d = begin_start[15:0];
              val_len_d = begin_len[5:0];
            end
            rlp_tfp_pkg::FIELD_DATA: begin
              data_off_d = begin_start[15:0];
              data_len_d = begin_len;
            end
            rlp_tfp_pkg::FIELD_V: begin
              chain_d = 7'd0;
            end
            default: begin
            end
          endcase
          if (!err_d) begin
            item_one_d = (begin_len == 16'd1);
            fin_one    = item_one_d;
            if (begin_bare) begin
              num_acc_d = {32'd0, b};
              fin_acc   = {32'd0, b};
              fin_v     = 1'b1;
            end else if (begin_len == 16'd0) begin
              num_acc_d = 40'd0;
              fin_acc   = 40'd0;
              fin_v     = 1'b1;
            end else begin
              num_acc_d = 40'd0;
              phase_d   = rlp_tfp_pkg::PH_BODY;
            end
          end
        end
      end

      // Item body complete: store the numeric fields.
      if (fin_v) begin
        case (fi_q)
          rlp_tfp_pkg::FIELD_NONCE:     nonce_d     = fin_acc[31:0];
          rlp_tfp_pkg::FIELD_GAS_PRICE: gas_price_d = fin_acc;
          rlp_tfp_pkg::FIELD_GAS_LIMIT: gas_limit_d = fin_acc[31:0];
          rlp_tfp_pkg::FIELD_V: begin
            v_minus = fin_acc[7:0] - rlp_tfp_pkg::V_OFFSET;
            if (fin_one && fin_acc >= 40'(rlp_tfp_pkg::V_MIN)) chain_d = v_minus[7:1];
            else chain_d = 7'd0;
          end
          default: begin
          end
        endcase
        if (fi_q < rlp_tfp_pkg::FIELD_DONE) fi_d = fi_q + 4'd1;
        phase_d = rlp_tfp_pkg::PH_ITEM;
      end

      if (pos_q != '1) pos_d = pos_q + PW'(1);

      if (beat_i.last) begin
        ok = !err_d && phase_d == rlp_tfp_pkg::PH_ITEM && fi_d == rlp_tfp_pkg::FIELD_DONE &&
             cur_p1 == list_end_d;
        if (ok) begin
          res_o.ok             = 1'b1;
          res_o.nonce          = nonce_d;
          res_o.gas_price_high = gas_price_d[39:16];
          res_o.gas_price_low  = gas_price_d[15:0];
          res_o.gas_limit      = gas_limit_d;
          res_o.has_address    = has_addr_d;
          res_o.address_offset = addr_off_d;
          res_o.value_offset   = val_off_d;
          res_o.value_length   = val_len_d;
          res_o.data_offset    = data_off_d;
          res_o.data_length    = data_len_d;
          res_o.chain_id       = chain_d;
        end
        phase_d = rlp_tfp_pkg::PH_OUTER;
        fi_d    = rlp_tfp_pkg::FIELD_NO_LIST;
        pos_d   = '0;
        err_d   = 1'b0;
      end
    end
  end

  assign res_valid_o = step_i && beat_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rlp_tfp_pkg::PH_OUTER;
      fi_q    <= rlp_tfp_pkg::FIELD_NO_LIST;
      pos_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fi_q    <= fi_d;
      pos_q   <= pos_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    list_end_q  <= list_end_d;
    item_end_q  <= item_end_d;
    lbl_q       <= lbl_d;
    len_acc_q   <= len_acc_d;
    num_acc_q   <= num_acc_d;
    item_one_q  <= item_one_d;
    nonce_q     <= nonce_d;
    gas_price_q <= gas_price_d;
    gas_limit_q <= gas_limit_d;
    has_addr_q  <= has_addr_d;
    addr_off_q  <= addr_off_d;
    val_off_q   <= val_off_d;
    val_len_q   <= val_len_d;
    data_off_q  <= data_off_d;
    data_len_q  <= data_len_d;
    chain_q     <= chain_d;
  end

endmodule

`default_nettype wire

### design/rlp_transaction_field_parser.sv
// Channel  Dir  Payload                                  Accept
// in_i     in   byte_in[7:0], last                       valid && ready
// out_o    out  ok, nonce, gas price, gas limit, to,     valid && ready
//               value/data offsets+lengths, chain_id
//
// One byte per cycle while in_i.ready is high. A last byte's result is registered to out_o.
// Path: input register -> header/length/accumulator update -> result register.
// in_i.ready drops only while a result waits in out_o and the registered byte is a last byte.
// Reset (rst_ni low, async) returns the parser to expecting an outer list header.
`default_nettype none

module rlp_transaction_field_parser #(
  parameter int POSITION_BITS = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  rlp_tfp_in_if.sink       in_i,
  rlp_tfp_out_if.source    out_o
);

  logic                 s1_valid_q, s1_valid_d;
  rlp_tfp_pkg::beat_t   s1_q;
  logic                 s1_adv;
  logic                 in_accept;
  logic                 out_valid_q, out_valid_d;
  rlp_tfp_pkg::result_t out_q;
  logic                 res_valid;
  rlp_tfp_pkg::result_t res;

  assign s1_adv      = !s1_q.last || !out_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign in_accept   = in_i.valid && in_i.ready;
  assign s1_valid_d  = in_accept || (s1_valid_q && !s1_adv);
  assign out_valid_d = res_valid || (out_valid_q && !out_o.ready);

  rlp_tfp_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_valid_q && s1_adv),
    .beat_i     (s1_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.byte_in <= in_i.byte_in;
      s1_q.last    <= in_i.last;
    end
    if (res_valid) out_q <= res;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.ok             = out_q.ok;
  assign out_o.nonce          = out_q.nonce;
  assign out_o.gas_price_high = out_q.gas_price_high;
  assign out_o.gas_price_low  = out_q.gas_price_low;
  assign out_o.gas_limit      = out_q.gas_limit;
  assign out_o.has_address    = out_q.has_address;
  assign out_o.address_offset = out_q.address_offset;
  assign out_o.value_offset   = out_q.value_offset;
  assign out_o.value_length   = out_q.value_length;
  assign out_o.data_offset    = out_q.data_offset;
  assign out_o.data_length    = out_q.data_length;
  assign out_o.chain_id       = out_q.chain_id;

endmodule

`default_nettype wire

### design/rlp_tfp_checker.sv
`default_nettype none

`include "rlp_transaction_field_parser_assert.svh"

module rlp_tfp_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        in_last_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire        ok_i,
  input wire [31:0] nonce_i,
  input wire [23:0] gas_price_high_i,
  input wire [15:0] gas_price_low_i,
  input wire [31:0] gas_limit_i,
  input wire        has_address_i,
  input wire [15:0] address_offset_i,
  input wire [15:0] value_offset_i,
  input wire [5:0]  value_length_i,
  input wire [15:0] data_offset_i,
  input wire [15:0] data_length_i,
  input wire [6:0]  chain_id_i
);

  `RLP_TFP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")

  `RLP_TFP_ASSERT(a_out_from_last, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i, 2), "result without last byte")

  `RLP_TFP_ASSERT(a_stall_only_on_result, !in_ready_i |-> out_valid_i, "input stalled with no waiting result")

  `RLP_TFP_ASSERT(a_fail_zero, out_valid_i && !ok_i |-> nonce_i == 32'd0 && gas_price_high_i == 24'd0 && gas_price_low_i == 16'd0 && gas_limit_i == 32'd0 && !has_address_i && address_offset_i == 16'd0 && value_offset_i == 16'd0 && value_length_i == 6'd0 && data_offset_i == 16'd0 && data_length_i == 16'd0 && chain_id_i == 7'd0, "failed result carries field data")

  `RLP_TFP_ASSERT(a_ok_ranges, out_valid_i && ok_i |-> value_length_i <= 6'd32 && chain_id_i <= 7'd110, "field out of range")

endmodule

bind rlp_transaction_field_parser rlp_tfp_checker u_rlp_tfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_last_i       (in_i.last),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .ok_i            (out_o.ok),
  .nonce_i         (out_o.nonce),
  .gas_price_high_i(out_o.gas_price_high),
  .gas_price_low_i (out_o.gas_price_low),
  .gas_limit_i     (out_o.gas_limit),
  .has_address_i   (out_o.has_address),
  .address_offset_i(out_o.address_offset),
  .value_offset_i  (out_o.value_offset),
  .value_length_i  (out_o.value_length),
  .data_offset_i   (out_o.data_offset),
  .data_length_i   (out_o.data_length),
  .chain_id_i      (out_o.chain_id)
);

`default_nettype wire
